// File: hdl/sfov_pkg.sv
// ----------------------------------------------------------------------------
// sfov_pkg
// Shared types, codes and helpers of the shadowcasting field-of-view unit.
// ----------------------------------------------------------------------------
package sfov_pkg;

	// signed width of coordinates, scan lines, offsets and slope terms
	localparam int CW     = 12;
	localparam int DIM_W  = 9;   // effective map side, up to 127
	localparam int RAD_W  = 9;   // effective radius, up to 255
	localparam int D2_W   = 18;  // squared distance
	localparam int ROOT_W = 9;   // square root of a D2_W value
	localparam int DIST_W = 7;
	localparam int VIS_W  = 8;   // visible flag and distance
	localparam int PADDR_W = 3;

	localparam logic [PADDR_W-1:0] ADDR_MAP_WIDTH  = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_MAP_HEIGHT = 3'd4;

	typedef logic signed [CW-1:0] crd_t;
	typedef logic signed [1:0]    coef_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_RUN   = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ORIGIN = 2'd1,
		ST_ADDR   = 2'd2,
		ST_RSVD   = 2'd3
	} status_t;

	// one scan frame of an octant
	typedef struct packed {
		crd_t line;
		crd_t dx;
		logic blocked;
		crd_t sn;
		crd_t sd;
		crd_t en;
		crd_t ed;
		crd_t nn;
		crd_t nd;
	} frame_t;

	// octant transform: ax = ox + dx*XX + dy*XY, ay = oy + dx*YX + dy*YY
	localparam coef_t OCT_XX [8] = '{2'sb01, 2'sb00, 2'sb00, 2'sb11,
		2'sb11, 2'sb00, 2'sb00, 2'sb01};
	localparam coef_t OCT_XY [8] = '{2'sb00, 2'sb01, 2'sb11, 2'sb00,
		2'sb00, 2'sb11, 2'sb01, 2'sb00};
	localparam coef_t OCT_YX [8] = '{2'sb00, 2'sb01, 2'sb01, 2'sb00,
		2'sb00, 2'sb11, 2'sb11, 2'sb00};
	localparam coef_t OCT_YY [8] = '{2'sb01, 2'sb00, 2'sb00, 2'sb01,
		2'sb11, 2'sb00, 2'sb00, 2'sb11};

	// a/b < c/d with positive denominators
	function automatic logic slope_lt(crd_t an, crd_t ad, crd_t bn, crd_t bd);
		logic signed [2*CW-1:0] p1;
		logic signed [2*CW-1:0] p2;
		p1 = an * bd;
		p2 = bn * ad;
		return p1 < p2;
	endfunction

	function automatic crd_t coef_term(crd_t v, coef_t m);
		crd_t r;
		unique case (m)
			2'sb01:  r = v;
			2'sb11:  r = -v;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/sfov_ram.sv
// ----------------------------------------------------------------------------
// sfov_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sfov_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/sfov_isqrt.sv
// ----------------------------------------------------------------------------
// sfov_isqrt
// Iterative floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sfov_isqrt
	import sfov_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [D2_W-1:0]   value,
	output logic              done,
	output logic [ROOT_W-1:0] root
);

	localparam int BIT_W = $clog2(ROOT_W);

	logic [D2_W-1:0]   val_q;
	logic [ROOT_W-1:0] root_q;
	logic [BIT_W-1:0]  bit_q;
	logic              busy_q;
	logic              done_q;
	logic [ROOT_W-1:0] cand;
	logic [D2_W-1:0]   cand_sq;

	assign cand    = root_q | (ROOT_W'(1) << bit_q);
	assign cand_sq = cand * cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && bit_q == '0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= value;
			root_q <= '0;
			bit_q  <= BIT_W'(ROOT_W - 1);
		end else if (busy_q) begin
			if (cand_sq <= val_q) begin
				root_q <= cand;
			end
			bit_q <= bit_q - 1'b1;
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// File: hdl/shadowcast_field_of_view_unit.sv
// ----------------------------------------------------------------------------
// shadowcast_field_of_view_unit
// Grid field of view by recursive shadowcasting over eight octants.
// ----------------------------------------------------------------------------
// A run item first clears the visibility memory, then works scan steps (a
// cell in the map, a nested scan start, or a pop) and waits on the square
// root unit for each lit cell.
// One item is worked at a time; the output register lets the next item in.
// After reset both cell memories are cleared, one cell per cycle, over all
// MAP_WIDTH*MAP_HEIGHT cells; no item is taken meanwhile, config still is.
// ----------------------------------------------------------------------------
module shadowcast_field_of_view_unit
	import sfov_pkg::*;
#(
	parameter int MAP_WIDTH   = 64,
	parameter int MAP_HEIGHT  = 64,
	parameter int STACK_DEPTH = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// items in
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic               opaque,
	input  logic [7:0]         radius,
	// results out
	output logic               out_valid,
	input  logic               out_ready,
	output logic               visible,
	output logic [DIST_W-1:0]  distance,
	output logic [1:0]         status
);

	localparam int CELLS  = MAP_WIDTH * MAP_HEIGHT;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SA_W   = $clog2(STACK_DEPTH);
	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int FR_W   = $bits(frame_t);
	localparam logic [DIM_W-1:0] MAX_W = DIM_W'(MAP_WIDTH);
	localparam logic [DIM_W-1:0] MAX_H = DIM_W'(MAP_HEIGHT);

	typedef enum logic [13:0] {
		S_IDLE     = 14'b00000000000001,
		S_CLEAR    = 14'b00000000000010,
		S_ORIGIN   = 14'b00000000000100,
		S_OCT_INIT = 14'b00000000001000,
		S_STEP     = 14'b00000000010000,
		S_CMP2     = 14'b00000000100000,
		S_CELL     = 14'b00000001000000,
		S_CELL2    = 14'b00000010000000,
		S_SQRT     = 14'b00000100000000,
		S_UPDATE   = 14'b00001000000000,
		S_PUSH     = 14'b00010000000000,
		S_POP_WAIT = 14'b00100000000000,
		S_RD_WAIT  = 14'b01000000000000,
		S_RESP     = 14'b10000000000000
	} state_t;

	state_t state_q;

	// ---------------------------------------------------------------- config
	logic [6:0] map_width_q;
	logic [6:0] map_height_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= 7'd64;
			map_height_q <= 7'd64;
		end else if (cfg_wr) begin
			if (paddr == ADDR_MAP_WIDTH) begin
				map_width_q <= pwdata[6:0];
			end
			if (paddr == ADDR_MAP_HEIGHT) begin
				map_height_q <= pwdata[6:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_MAP_WIDTH) begin
			prdata = 32'(map_width_q);
		end else if (paddr == ADDR_MAP_HEIGHT) begin
			prdata = 32'(map_height_q);
		end
	end

	// effective map size: zero acts as one, oversize clamps to the array
	logic [DIM_W-1:0] w_raw, h_raw, w_eff, h_eff, side_max;

	assign w_raw    = DIM_W'(map_width_q);
	assign h_raw    = DIM_W'(map_height_q);
	assign w_eff    = (w_raw == '0) ? DIM_W'(1) : ((w_raw > MAX_W) ? MAX_W : w_raw);
	assign h_eff    = (h_raw == '0) ? DIM_W'(1) : ((h_raw > MAX_H) ? MAX_H : h_raw);
	assign side_max = (w_eff > h_eff) ? w_eff : h_eff;

	// ------------------------------------------------------------ input decode
	logic              in_acc;
	logic              in_inside;
	logic [ADDR_W-1:0] in_addr;
	logic [RAD_W-1:0]  rad_in;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign in_inside = (DIM_W'(row) < h_eff) && (DIM_W'(col) < w_eff);
	assign in_addr   = ADDR_W'(int'(row) * MAP_WIDTH + int'(col));
	assign rad_in    = (radius == '0) ? RAD_W'(side_max) : RAD_W'(radius);

	// ------------------------------------------------------------ run state
	frame_t            cur_q;
	logic [SP_W-1:0]   sp_q;
	logic [2:0]        oct_q;
	crd_t              ox_q, oy_q;
	logic [RAD_W-1:0]  rad_q;
	logic [D2_W-1:0]   r2_q;
	logic [ADDR_W-1:0] org_addr_q;
	logic [ADDR_W-1:0] clr_q;
	logic              clr_all_q;
	crd_t              ln_q, ld_q, rn_q, rd_q;
	crd_t              cdx_q, ci_q;
	logic [ADDR_W-1:0] cell_addr_q;
	logic [D2_W-1:0]   d2_q;
	logic              opq_q;

	// result staging and output register
	logic              res_vis_q;
	logic [DIST_W-1:0] res_dist_q;
	status_t           res_status_q;
	logic              out_valid_q;
	logic              out_vis_q;
	logic [DIST_W-1:0] out_dist_q;
	status_t           out_status_q;

	// ------------------------------------------------------------ step logic
	crd_t i_c, dx_c, ln_c, ld_c, rn_c, rd_c, rad_s;
	logic past_rad, step_cmp1, cmp2_c;

	assign i_c       = cur_q.line;
	assign dx_c      = cur_q.dx;
	assign rad_s     = crd_t'(rad_q);
	assign past_rad  = i_c > rad_s;
	assign ln_c      = crd_t'(1) - (dx_c <<< 1);
	assign ld_c      = (i_c <<< 1) - crd_t'(1);
	assign rn_c      = crd_t'(-1) - (dx_c <<< 1);
	assign rd_c      = (i_c <<< 1) + crd_t'(1);
	// start slope below the cell's right edge: cell not reached yet
	assign step_cmp1 = slope_lt(cur_q.sn, cur_q.sd, rn_c, rd_c);
	// cell's left edge below end slope: rest of the line is out
	assign cmp2_c    = slope_lt(ln_q, ld_q, cur_q.en, cur_q.ed);

	// cell position in map coordinates
	crd_t              cdy, ax, ay;
	logic              cell_in;
	logic [ADDR_W-1:0] cell_addr;
	logic signed [2*CW-1:0] sq_dx, sq_dy;

	assign cdy     = -ci_q;
	assign ax      = ox_q + coef_term(cdx_q, OCT_XX[oct_q]) + coef_term(cdy, OCT_XY[oct_q]);
	assign ay      = oy_q + coef_term(cdx_q, OCT_YX[oct_q]) + coef_term(cdy, OCT_YY[oct_q]);
	assign cell_in = !ax[CW-1] && !ay[CW-1] && (ax < crd_t'(w_eff)) && (ay < crd_t'(h_eff));
	assign cell_addr = ADDR_W'(int'(ay) * MAP_WIDTH + int'(ax));
	assign sq_dx   = cdx_q * cdx_q;
	assign sq_dy   = ci_q * ci_q;

	// nested scan start
	logic push_ok;
	assign push_ok = !slope_lt(cur_q.sn, cur_q.sd, ln_q, ld_q)
		&& (sp_q < SP_W'(STACK_DEPTH));

	// ------------------------------------------------------------ square root
	logic              sq_start, sq_done;
	logic [ROOT_W-1:0] sq_root;
	logic [DIST_W-1:0] sq_dist;

	assign sq_start = (state_q == S_CELL2) && (d2_q < r2_q);
	assign sq_dist  = (sq_root > ROOT_W'(127)) ? DIST_W'(127) : sq_root[DIST_W-1:0];

	sfov_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.value  (d2_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// ------------------------------------------------------------ memories
	logic              opa_we, opa_wdata, opa_rdata;
	logic [ADDR_W-1:0] opa_waddr;
	logic              vis_we;
	logic [ADDR_W-1:0] vis_waddr;
	logic [VIS_W-1:0]  vis_wdata, vis_rdata;
	logic              stk_we;
	logic [SP_W-1:0]   sp_m1, sp_m2;
	logic [FR_W-1:0]   stk_rdata;

	assign sp_m1 = sp_q - SP_W'(1);
	assign sp_m2 = sp_q - SP_W'(2);

	always_comb begin
		opa_we    = 1'b0;
		opa_waddr = in_addr;
		opa_wdata = opaque;
		if (state_q == S_CLEAR) begin
			opa_we    = clr_all_q;
			opa_waddr = clr_q;
			opa_wdata = 1'b0;
		end else if (in_acc && operation == OP_WRITE && in_inside) begin
			opa_we = 1'b1;
		end
	end

	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = clr_q;
		vis_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				vis_we = 1'b1;
			end
			S_ORIGIN: begin
				vis_we    = 1'b1;
				vis_waddr = org_addr_q;
				vis_wdata = 8'h80;
			end
			S_SQRT: begin
				vis_we    = sq_done;
				vis_waddr = cell_addr_q;
				vis_wdata = {1'b1, sq_dist};
			end
			default: begin
				vis_we = 1'b0;
			end
		endcase
	end

	assign stk_we = (state_q == S_PUSH) && push_ok;

	sfov_ram #(.WIDTH(1), .DEPTH(CELLS)) u_opacity (
		.clk   (clk),
		.we    (opa_we),
		.waddr (opa_waddr),
		.wdata (opa_wdata),
		.raddr (cell_addr),
		.rdata (opa_rdata)
	);

	sfov_ram #(.WIDTH(VIS_W), .DEPTH(CELLS)) u_visibility (
		.clk   (clk),
		.we    (vis_we),
		.waddr (vis_waddr),
		.wdata (vis_wdata),
		.raddr (in_addr),
		.rdata (vis_rdata)
	);

	// frames below the top one; the top frame lives in cur_q
	sfov_ram #(.WIDTH(FR_W), .DEPTH(STACK_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (sp_m1[SA_W-1:0]),
		.wdata (cur_q),
		.raddr (sp_m2[SA_W-1:0]),
		.rdata (stk_rdata)
	);

	// ------------------------------------------------------------ sequencer
	logic res_load;
	assign res_load = (state_q == S_RESP) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_all_q   <= 1'b1;
			clr_q       <= '0;
			sp_q        <= '0;
			oct_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (operation == OP_RUN && in_inside) begin
							state_q   <= S_CLEAR;
							clr_all_q <= 1'b0;
							clr_q     <= '0;
						end else if (operation == OP_READ && in_inside) begin
							state_q <= S_RD_WAIT;
						end else begin
							state_q <= S_RESP;
						end
					end
				end
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CELLS - 1)) begin
						state_q <= clr_all_q ? S_IDLE : S_ORIGIN;
					end
				end
				S_ORIGIN: begin
					oct_q   <= '0;
					state_q <= S_OCT_INIT;
				end
				S_OCT_INIT: begin
					sp_q    <= SP_W'(1);
					state_q <= S_STEP;
				end
				S_STEP: begin
					// pop when past the radius, or when a line ends blocked
					if (past_rad || (dx_c > crd_t'(0) && cur_q.blocked)) begin
						sp_q <= sp_m1;
						if (sp_q == SP_W'(1)) begin
							if (oct_q == 3'd7) begin
								state_q <= S_RESP;
							end else begin
								oct_q   <= oct_q + 1'b1;
								state_q <= S_OCT_INIT;
							end
						end else begin
							state_q <= S_POP_WAIT;
						end
					end else if (dx_c <= crd_t'(0) && !step_cmp1) begin
						state_q <= S_CMP2;
					end
				end
				S_CMP2: begin
					state_q <= cmp2_c ? S_STEP : S_CELL;
				end
				S_CELL: begin
					state_q <= cell_in ? S_CELL2 : S_STEP;
				end
				S_CELL2: begin
					state_q <= sq_start ? S_SQRT : S_UPDATE;
				end
				S_SQRT: begin
					if (sq_done) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					state_q <= (!cur_q.blocked && opq_q) ? S_PUSH : S_STEP;
				end
				S_PUSH: begin
					if (push_ok) begin
						sp_q <= sp_q + 1'b1;
					end
					state_q <= S_STEP;
				end
				S_POP_WAIT: begin
					state_q <= S_STEP;
				end
				S_RD_WAIT: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ox_q         <= crd_t'(col);
				oy_q         <= crd_t'(row);
				org_addr_q   <= in_addr;
				rad_q        <= rad_in;
				r2_q         <= D2_W'(rad_in) * D2_W'(rad_in);
				res_vis_q    <= 1'b0;
				res_dist_q   <= '0;
				if (operation == OP_RUN && !in_inside) begin
					res_status_q <= ST_ORIGIN;
				end else if ((operation == OP_WRITE || operation == OP_READ)
					&& !in_inside) begin
					res_status_q <= ST_ADDR;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			S_OCT_INIT: begin
				cur_q.line    <= crd_t'(1);
				cur_q.dx      <= crd_t'(-1);
				cur_q.blocked <= 1'b0;
				cur_q.sn      <= crd_t'(1);
				cur_q.sd      <= crd_t'(1);
				cur_q.en      <= crd_t'(0);
				cur_q.ed      <= crd_t'(1);
				cur_q.nn      <= crd_t'(1);
				cur_q.nd      <= crd_t'(1);
			end
			S_STEP: begin
				ln_q  <= ln_c;
				ld_q  <= ld_c;
				rn_q  <= rn_c;
				rd_q  <= rd_c;
				cdx_q <= dx_c;
				ci_q  <= i_c;
				if (!past_rad) begin
					if (dx_c > crd_t'(0)) begin
						if (!cur_q.blocked) begin
							cur_q.line <= i_c + crd_t'(1);
							cur_q.dx   <= -(i_c + crd_t'(1));
						end
					end else if (step_cmp1) begin
						cur_q.dx <= dx_c + crd_t'(1);
					end
				end
			end
			S_CMP2: begin
				cur_q.dx <= cmp2_c ? crd_t'(1) : cdx_q + crd_t'(1);
			end
			S_CELL: begin
				cell_addr_q <= cell_addr;
				d2_q        <= D2_W'(sq_dx + sq_dy);
			end
			S_CELL2: begin
				opq_q <= opa_rdata;
			end
			S_UPDATE: begin
				if (cur_q.blocked) begin
					if (opq_q) begin
						cur_q.nn <= rn_q;
						cur_q.nd <= rd_q;
					end else begin
						cur_q.blocked <= 1'b0;
						cur_q.sn      <= cur_q.nn;
						cur_q.sd      <= cur_q.nd;
					end
				end else if (opq_q) begin
					cur_q.blocked <= 1'b1;
					cur_q.nn      <= rn_q;
					cur_q.nd      <= rd_q;
				end
			end
			S_PUSH: begin
				if (push_ok) begin
					cur_q.line    <= ci_q + crd_t'(1);
					cur_q.dx      <= -(ci_q + crd_t'(1));
					cur_q.blocked <= 1'b0;
					cur_q.en      <= ln_q;
					cur_q.ed      <= ld_q;
					cur_q.nn      <= cur_q.sn;
					cur_q.nd      <= cur_q.sd;
				end
			end
			S_POP_WAIT: begin
				cur_q <= frame_t'(stk_rdata);
			end
			S_RD_WAIT: begin
				res_vis_q  <= vis_rdata[VIS_W-1];
				res_dist_q <= vis_rdata[DIST_W-1:0];
			end
			S_RESP: begin
				if (res_load) begin
					out_vis_q    <= res_vis_q;
					out_dist_q   <= res_dist_q;
					out_status_q <= res_status_q;
				end
			end
			default: begin
				opq_q <= opq_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign visible   = out_vis_q;
	assign distance  = out_dist_q;
	assign status    = out_status_q;

	// ------------------------------------------------------------ assertions
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("slope stack pointer beyond depth");

	a_out_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RESP))
		else $error("result shown without response state");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != S_IDLE)
		else $error("accepted item did not start");

	a_sqrt_in_cell: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == S_SQRT)
		else $error("square root finished outside its wait state");

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the shadowcasting field-of-view unit against a behavioral predictor:
// directed corner cases first, then random write/run/read traffic on small
// maps, with random idle cycles on both item channels.
// ----------------------------------------------------------------------------
module testbench
	import sfov_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MW = 64;
	localparam int MH = 64;
	localparam int SDEPTH = 128;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		op_t        op;
		logic [5:0] row;
		logic [5:0] col;
		logic       opq;
		logic [7:0] rad;
	} fov_item_t;

	typedef struct {
		logic       vis;
		logic [6:0] dval;
		status_t    st;
	} fov_result_t;

	typedef struct {
		int line, dx;
		bit blocked;
		int sn, sd, en, ed, nn, nd;
	} scan_frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] operation = '0;
	logic [5:0] row = '0;
	logic [5:0] col = '0;
	logic       opaque = 1'b0;
	logic [7:0] radius = '0;

	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       visible;
	logic [6:0] distance;
	logic [1:0] status;

	shadowcast_field_of_view_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.row(row), .col(col), .opaque(opaque), .radius(radius),
		.out_valid(out_valid), .out_ready(out_ready), .visible(visible),
		.distance(distance), .status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- state
	fov_item_t   items_pending[$];
	fov_result_t fov_results_due[$];
	bit          calm = 1'b0;   // no idling on either side while set
	int          failures = 0;
	int          cycles = 0;
	int          n_runs = 0;
	int          n_reads = 0;

	// predictor's copy of the block
	logic [6:0]  cfg_w = 7'd64;
	logic [6:0]  cfg_h = 7'd64;
	bit          opacity_map [MW*MH];
	logic [7:0]  seen_map [MW*MH];
	scan_frame_t frames [SDEPTH];
	int          depth;

	function automatic int eff_side(logic [6:0] v, int maxv);
		if (v == 0) return 1;
		if (v > maxv) return maxv;
		return int'(v);
	endfunction

	// a/b < c/d, denominators positive
	function automatic bit frac_lt(int an, int ad, int bn, int bd);
		return an * bd < bn * ad;
	endfunction

	function automatic int root_floor(int v);
		int r;
		r = 0;
		while ((r + 1) * (r + 1) <= v) r++;
		return r;
	endfunction

	function automatic void open_frame(int line, int sn, int sd, int en, int ed);
		if (frac_lt(sn, sd, en, ed)) return;
		if (depth >= SDEPTH) return;   // stack full: nested scan skipped
		frames[depth] = '{line, -line, 1'b0, sn, sd, en, ed, sn, sd};
		depth++;
	endfunction

	function automatic void sweep_octant(int oy, int ox, int w, int h, int rad, int oct);
		int xx, xy, yx, yy, t, i, dx, dy, ln, ld, rn, rd, ax, ay, idx, d2, d;
		bit opq;
		xx = int'(OCT_XX[oct]);
		xy = int'(OCT_XY[oct]);
		yx = int'(OCT_YX[oct]);
		yy = int'(OCT_YY[oct]);
		depth = 0;
		open_frame(1, 1, 1, 0, 1);
		while (depth > 0) begin
			t = depth - 1;
			i = frames[t].line;
			dx = frames[t].dx;
			if (i > rad) begin
				depth--;
				continue;
			end
			if (dx > 0) begin
				// end of line: a frame that ends in shadow is done
				if (frames[t].blocked) begin
					depth--;
					continue;
				end
				frames[t].line = i + 1;
				frames[t].dx = -(i + 1);
				frames[t].blocked = 1'b0;
				continue;
			end
			dy = -i;
			ln = 1 - 2 * dx; ld = 2 * i - 1;
			rn = -1 - 2 * dx; rd = 2 * i + 1;
			if (frac_lt(frames[t].sn, frames[t].sd, rn, rd)) begin
				frames[t].dx = dx + 1;
				continue;
			end
			if (frac_lt(ln, ld, frames[t].en, frames[t].ed)) begin
				frames[t].dx = 1;
				continue;
			end
			frames[t].dx = dx + 1;
			ax = ox + dx * xx + dy * xy;
			ay = oy + dx * yx + dy * yy;
			if (ax < 0 || ay < 0 || ax >= w || ay >= h) continue;
			idx = ay * MW + ax;
			d2 = dx * dx + dy * dy;
			if (d2 < rad * rad) begin
				d = root_floor(d2);
				if (d > 127) d = 127;
				seen_map[idx] = 8'h80 | 8'(d);
			end
			opq = opacity_map[idx];
			if (frames[t].blocked) begin
				if (opq) begin
					frames[t].nn = rn; frames[t].nd = rd;
				end else begin
					frames[t].blocked = 1'b0;
					frames[t].sn = frames[t].nn; frames[t].sd = frames[t].nd;
				end
			end else if (opq) begin
				frames[t].blocked = 1'b1;
				frames[t].nn = rn; frames[t].nd = rd;
				open_frame(i + 1, frames[t].sn, frames[t].sd, ln, ld);
			end
		end
	endfunction

	function automatic fov_result_t fov_compute(fov_item_t it);
		fov_result_t res;
		int w, h, idx, rad;
		bit in_map;
		w = eff_side(cfg_w, MW);
		h = eff_side(cfg_h, MH);
		in_map = (int'(it.row) < h) && (int'(it.col) < w);
		idx = int'(it.row) * MW + int'(it.col);
		res = '{1'b0, 7'd0, ST_OK};
		case (it.op)
			OP_WRITE: begin
				if (in_map) opacity_map[idx] = it.opq;
				else res.st = ST_ADDR;
			end
			OP_RUN: begin
				if (!in_map) begin
					res.st = ST_ORIGIN;
				end else begin
					rad = (it.rad == 0) ? ((w > h) ? w : h) : int'(it.rad);
					foreach (seen_map[k]) seen_map[k] = 8'h00;
					seen_map[idx] = 8'h80;
					for (int oct = 0; oct < 8; oct++)
						sweep_octant(int'(it.row), int'(it.col), w, h, rad, oct);
				end
			end
			OP_READ: begin
				if (in_map) begin
					res.vis = seen_map[idx][7];
					res.dval = seen_map[idx][6:0];
				end else begin
					res.st = ST_ADDR;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	initial begin
		foreach (opacity_map[k]) opacity_map[k] = 1'b0;
		foreach (seen_map[k]) seen_map[k] = 8'h00;
	end

	// --------------------------------------------------------------- driver
	always @(posedge clk) begin : item_driver
		fov_item_t nxt;
		bit fire;
		if (arst_n) begin
			fire = in_valid && in_ready;
			if (fire) begin
				fov_results_due.push_back(fov_compute(fov_item_t'{op_t'(operation), row,
					col, opaque, radius}));
				if (op_t'(operation) == OP_RUN) n_runs++;
				if (op_t'(operation) == OP_READ) n_reads++;
			end
			if (!in_valid || fire) begin
				if (items_pending.size() > 0 && (calm || $urandom_range(0, 99) >= 34)) begin
					nxt = items_pending.pop_front();
					in_valid  <= 1'b1;
					operation <= nxt.op;
					row       <= nxt.row;
					col       <= nxt.col;
					opaque    <= nxt.opq;
					radius    <= nxt.rad;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// -------------------------------------------------------------- monitor
	always @(posedge clk) begin : result_monitor
		fov_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (fov_results_due.size() == 0) begin
					$error("result with no item outstanding: visible=%0d distance=%0d status=%0d",
						visible, distance, status);
					failures++;
				end else begin
					want = fov_results_due.pop_front();
					if (visible !== want.vis) begin
						$error("visible: expected %0d, got %0d", want.vis, visible);
						failures++;
					end
					if (distance !== want.dval) begin
						$error("distance: expected %0d, got %0d", want.dval, distance);
						failures++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						failures++;
					end
				end
			end
			out_ready <= calm || ($urandom_range(0, 99) >= 34);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------- stimulus
	function automatic void queue_item(op_t op, int r, int c, bit o, int rad);
		items_pending.push_back('{op, 6'(r), 6'(c), o, 8'(rad)});
	endfunction

	// wait for all items to drain, then let the block fall idle
	task automatic drain();
		while (items_pending.size() > 0 || in_valid || fov_results_due.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// register write: setup cycle then access cycle
	task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_MAP_WIDTH) cfg_w = data[6:0];
		else cfg_h = data[6:0];
	endtask

	task automatic set_map(int w, int h);
		reg_write(ADDR_MAP_WIDTH, 32'(w));
		reg_write(ADDR_MAP_HEIGHT, 32'(h));
	endtask

	// mostly well-formed traffic inside the map, some out-of-range noise
	task automatic random_burst(int n);
		int w, h, p;
		w = eff_side(cfg_w, MW);
		h = eff_side(cfg_h, MH);
		repeat (n) begin
			p = $urandom_range(0, 99);
			if (p < 35)
				queue_item(OP_WRITE, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
					$urandom_range(0, 2) == 0, $urandom_range(0, 255));
			else if (p < 50)
				queue_item(OP_RUN, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
					$urandom_range(0, 1), $urandom_range(0, 12));
			else if (p < 90)
				queue_item(OP_READ, $urandom_range(0, h - 1), $urandom_range(0, w - 1),
					$urandom_range(0, 1), $urandom_range(0, 255));
			else if (p < 96)
				queue_item(op_t'($urandom_range(0, 2)), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 1), $urandom_range(0, 15));
			else
				queue_item(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
					$urandom_range(0, 1), $urandom_range(0, 255));
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full 64x64 map: corners, writes, reads, idle operation, full sweep
		queue_item(OP_WRITE, 0, 1, 1, 0);
		queue_item(OP_WRITE, 63, 63, 1, 255);
		queue_item(OP_READ, 63, 0, 0, 0);
		queue_item(OP_NONE, 63, 63, 1, 255);
		queue_item(OP_RUN, 0, 0, 0, 0);
		queue_item(OP_READ, 0, 0, 0, 0);
		queue_item(OP_READ, 0, 1, 0, 0);
		queue_item(OP_READ, 0, 2, 0, 0);
		queue_item(OP_READ, 63, 0, 0, 0);
		queue_item(OP_READ, 63, 63, 0, 0);
		drain();

		// zero sizes act as one cell: origin and address outside the map
		set_map(0, 0);
		queue_item(OP_RUN, 0, 0, 0, 5);
		queue_item(OP_RUN, 1, 0, 0, 5);
		queue_item(OP_WRITE, 0, 1, 1, 0);
		queue_item(OP_READ, 0, 0, 0, 0);
		queue_item(OP_READ, 0, 63, 0, 0);
		drain();

		// 3x3 map, origin walled in: huge radius ends on the first line
		set_map(3, 3);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				if (r != 1 || c != 1) queue_item(OP_WRITE, r, c, 1, 0);
		queue_item(OP_RUN, 1, 1, 0, 255);
		queue_item(OP_READ, 2, 2, 0, 0);
		queue_item(OP_RUN, 1, 1, 0, 128);
		queue_item(OP_READ, 0, 1, 0, 0);
		drain();

		// oversize registers clamp to the full map; sweep around the walls
		set_map(127, 127);
		queue_item(OP_RUN, 40, 20, 0, 0);
		queue_item(OP_READ, 2, 2, 0, 0);
		queue_item(OP_READ, 63, 0, 0, 0);
		queue_item(OP_READ, 40, 63, 0, 0);
		drain();

		// random phases on small maps; the second runs with no idling
		for (int ph = 0; ph < 4; ph++) begin
			set_map($urandom_range(1, 16), $urandom_range(1, 16));
			calm = (ph == 1);
			random_burst(22);
			drain();
		end
		calm = 1'b0;

		$display("covered %0d runs and %0d reads over clamped, tiny and random map sizes",
			n_runs, n_reads);
		if (failures == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
